// ===== sv/q2e_pkg.sv =====
// Shared widths, constants and helper functions for the quaternion to Euler core.
// No dependencies; the other files of the core, apart from q2e_delay, import this package.
`default_nettype none

package q2e_pkg;

    // Field widths
    localparam int IN_W     = 16;
    localparam int THR_W    = 15;
    localparam int ROLL_W   = 15;
    localparam int PITCH_W  = 14;
    localparam int YAW_W    = 15;

    // Datapath widths
    localparam int PROD_W   = 32;   // 16x16 signed product
    localparam int MAT_W    = 35;   // Q4.28 matrix term with headroom
    localparam int S_W      = 30;   // clamped pitch sine, +/-2^28
    localparam int RAD_W    = 57;   // radicand 2^56 - s^2
    localparam int SQ_W     = 58;   // square root working width
    localparam int ROOT_W   = 29;   // root, at most 2^28
    localparam int SQ_STEPS = 29;   // one root bit per stage
    localparam int CORD_W   = 37;   // CORDIC x/y width
    localparam int ANG_W    = 26;   // angle in 2^-16 degree
    localparam int DEG_W    = 16;   // angle in 1/64 degree before packing
    localparam int TABLE_LEN = 24;

    // Pitch sine reaches the CORDIC after the squaring stage and the root stages
    localparam int ALIGN    = 1 + SQ_STEPS;

    localparam logic [THR_W-1:0]        THR_RESET = 15'd16384;
    localparam logic signed [MAT_W-1:0] ONE_Q28   = 35'sd268435456;
    localparam logic signed [ANG_W-1:0] DEG90     = 26'sd5898240;
    localparam logic signed [DEG_W-1:0] ROLL_LIM  = 16'sd11520;
    localparam logic signed [DEG_W-1:0] PITCH_LIM = 16'sd5760;

    // Rotation matrix terms, Q4.28
    typedef struct packed {
        logic signed [MAT_W-1:0] cxx;
        logic signed [MAT_W-1:0] cxy;
        logic signed [MAT_W-1:0] cxz;
        logic signed [MAT_W-1:0] cyz;
        logic signed [MAT_W-1:0] czz;
        logic signed [MAT_W-1:0] cyx;
        logic signed [MAT_W-1:0] cyy;
    } mat_terms_t;

    // Arctangent of 2^-i in 2^-16 degree, rounded
    function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 26'sd2949120;
            1:       v = 26'sd1740967;
            2:       v = 26'sd919879;
            3:       v = 26'sd466945;
            4:       v = 26'sd234379;
            5:       v = 26'sd117306;
            6:       v = 26'sd58666;
            7:       v = 26'sd29335;
            8:       v = 26'sd14668;
            9:       v = 26'sd7334;
            10:      v = 26'sd3667;
            11:      v = 26'sd1833;
            12:      v = 26'sd917;
            13:      v = 26'sd458;
            14:      v = 26'sd229;
            15:      v = 26'sd115;
            16:      v = 26'sd57;
            17:      v = 26'sd29;
            18:      v = 26'sd14;
            19:      v = 26'sd7;
            20:      v = 26'sd4;
            21:      v = 26'sd2;
            22:      v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

    // Round 2^-16 degree to 1/64 degree (add half, floor) and saturate
    function automatic logic signed [DEG_W-1:0] round_deg(
        input logic signed [ANG_W-1:0] a,
        input logic signed [DEG_W-1:0] lim
    );
        logic signed [ANG_W-1:0] t;
        logic signed [DEG_W-1:0] r;
        t = a + 26'sd512;
        r = DEG_W'(t >>> 10);
        if (r > lim)
        begin
            r = lim;
        end
        if (r < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/q2e_delay.sv =====
// Clock-enabled delay line of fixed depth.
// Depends on nothing; used to align side data with the root and CORDIC stages.
`default_nettype none

module q2e_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             ce,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift one place per enabled cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (ce)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

// ===== sv/q2e_matrix.sv =====
// Rotation matrix terms from a Q2.14 quaternion: product stage, then sum stage.
// Depends on q2e_pkg.
`default_nettype none

module q2e_matrix
    import q2e_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   ce,
    input  wire logic signed [IN_W-1:0] qx,
    input  wire logic signed [IN_W-1:0] qy,
    input  wire logic signed [IN_W-1:0] qz,
    input  wire logic signed [IN_W-1:0] qw,
    output mat_terms_t                  terms
);

    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, xy_reg, wz_reg;
    logic signed [PROD_W-1:0] xz_reg, wy_reg, yz_reg, wx_reg;
    mat_terms_t               terms_reg;
    mat_terms_t               terms_next;

    // Form all pairwise products
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            wz_reg <= qw * qz;
            xz_reg <= qx * qz;
            wy_reg <= qw * qy;
            yz_reg <= qy * qz;
            wx_reg <= qw * qx;
        end
    end

    // Combine products into matrix terms
    always_comb
    begin
        terms_next.cxx = ONE_Q28 - ((MAT_W'(yy_reg) + MAT_W'(zz_reg)) <<< 1);
        terms_next.cxy = (MAT_W'(xy_reg) + MAT_W'(wz_reg)) <<< 1;
        terms_next.cxz = (MAT_W'(xz_reg) - MAT_W'(wy_reg)) <<< 1;
        terms_next.cyz = (MAT_W'(yz_reg) + MAT_W'(wx_reg)) <<< 1;
        terms_next.czz = ONE_Q28 - ((MAT_W'(xx_reg) + MAT_W'(yy_reg)) <<< 1);
        terms_next.cyx = (MAT_W'(xy_reg) - MAT_W'(wz_reg)) <<< 1;
        terms_next.cyy = ONE_Q28 - ((MAT_W'(xx_reg) + MAT_W'(zz_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

`default_nettype wire

// ===== sv/q2e_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on q2e_pkg.
`default_nettype none

module q2e_sqrt
    import q2e_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              ce,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic      [ROOT_W-1:0] root
);

    logic [SQ_W-1:0] rem_in [SQ_STEPS];
    logic [SQ_W-1:0] res_in [SQ_STEPS];
    logic [SQ_W-1:0] rem_reg [SQ_STEPS-1];
    logic [SQ_W-1:0] res_reg [SQ_STEPS];

    assign rem_in[0] = SQ_W'(radicand);
    assign res_in[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (RAD_W - 1 - 2 * k);
        logic [SQ_W-1:0] trial;
        logic            take;

        assign trial = res_in[k] + BIT;
        assign take  = rem_in[k] >= trial;

        // Keep the bit when the remainder covers the trial value
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                res_reg[k] <= take ? ((res_in[k] >> 1) + BIT) : (res_in[k] >> 1);
            end
        end

        if (k < SQ_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k] <= take ? (rem_in[k] - trial) : rem_in[k];
                end
            end
            assign rem_in[k+1] = rem_reg[k];
            assign res_in[k+1] = res_reg[k];
        end
    end

    assign root = res_reg[SQ_STEPS-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/q2e_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) in 2^-16 degree.
// Depends on q2e_pkg. One quadrant-fold stage, then STEPS rotation stages.
`default_nettype none

module q2e_cordic
    import q2e_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     ce,
    input  wire logic signed [CORD_W-1:0] y_in,
    input  wire logic signed [CORD_W-1:0] x_in,
    output logic signed      [ANG_W-1:0]  angle
);

    logic signed [CORD_W-1:0] x_reg    [STEPS];
    logic signed [CORD_W-1:0] y_reg    [STEPS];
    logic signed [ANG_W-1:0]  ang_reg  [STEPS+1];
    logic                     zero_reg [STEPS+1];

    // Fold the left half plane onto the right, flag the zero vector
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg[0]   <= y_in;
                    y_reg[0]   <= -x_in;
                    ang_reg[0] <= DEG90;
                end
                else
                begin
                    x_reg[0]   <= -y_in;
                    y_reg[0]   <= x_in;
                    ang_reg[0] <= -DEG90;
                end
            end
            else
            begin
                x_reg[0]   <= x_in;
                y_reg[0]   <= y_in;
                ang_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [ANG_W-1:0] ATAN = atan_entry(i);
        logic                     up;

        assign up = y_reg[i] > 0;

        // Rotate toward the x axis and accumulate the angle
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                ang_reg[i+1]  <= up ? (ang_reg[i] + ATAN) : (ang_reg[i] - ATAN);
                zero_reg[i+1] <= zero_reg[i];
            end
        end

        if (i < STEPS - 1)
        begin : g_xy
            logic signed [CORD_W-1:0] xs;
            logic signed [CORD_W-1:0] ys;

            assign xs = x_reg[i] >>> i;
            assign ys = y_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    x_reg[i+1] <= up ? (x_reg[i] + ys) : (x_reg[i] - ys);
                    y_reg[i+1] <= up ? (y_reg[i] - xs) : (y_reg[i] + xs);
                end
            end
        end
    end

    assign angle = zero_reg[STEPS] ? '0 : ang_reg[STEPS];

endmodule

`default_nettype wire

// ===== sv/quaternion_to_euler_xyz_core.sv =====
// Quaternion to X-Y-Z Euler angles. The pitch path, with its 29-stage square root
// feeding the pitch CORDIC, is the longest; roll and yaw are delayed to match.
// Throughput: one word per cycle, fully pipelined, while the skid stage is empty.
// Reset (rst_n low, async) empties the pipeline and output stages and sets the
// gimbal threshold to 1.0. Depends on q2e_pkg, q2e_matrix, q2e_sqrt, q2e_cordic,
// q2e_delay.
`default_nettype none

module quaternion_to_euler_xyz_core
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // gimbal threshold register
    input  wire logic              cfg_we,
    input  wire logic [THR_W-1:0]  cfg_wdata,
    // quaternion in
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [63:0]       s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
    // angles out
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [47:0]            m_axis_tdata    // roll_angle, pitch_angle, yaw_angle, pad
);

    localparam int CORD_LAT = CORDIC_STEPS + 1;
    localparam int VLD_LAT  = 3 + ALIGN + CORD_LAT;
    localparam int OUT_W    = ROLL_W + PITCH_W + YAW_W;

    logic              ce;
    logic [THR_W-1:0]  thr_reg;
    mat_terms_t        terms;

    logic                     lock_pos_reg, lock_neg_reg;
    logic signed [S_W-1:0]    s_reg;
    logic signed [MAT_W-1:0]  roll_y_reg, roll_x_reg, yaw_y_reg, yaw_x_reg;
    logic signed [MAT_W-1:0]  sp, thr_q28, s_clamp;
    logic [RAD_W-1:0]         sq_reg;
    logic signed [2*S_W-1:0]  s_prod;
    logic [RAD_W-1:0]         radicand;
    logic [ROOT_W-1:0]        root;
    logic [S_W-1:0]           s_dly;
    logic [1:0]               lock_dly;
    logic signed [ANG_W-1:0]  roll_ang, yaw_ang, pitch_ang;
    logic [ANG_W-1:0]         roll_dly, yaw_dly;
    logic                     vld_dly;

    logic                     fin_valid_reg;
    logic [OUT_W-1:0]         fin_reg, fin_next;
    logic                     out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0]         out_reg, skid_reg;
    logic signed [DEG_W-1:0]  roll_deg, pitch_deg, yaw_deg;

    // Pipeline advances while the skid stage is free
    assign ce            = !skid_valid_reg;
    assign s_axis_tready = ce;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    q2e_matrix u_matrix (
        .clk   (clk),
        .ce    (ce),
        .qx    (s_axis_tdata[15:0]),
        .qy    (s_axis_tdata[31:16]),
        .qz    (s_axis_tdata[47:32]),
        .qw    (s_axis_tdata[63:48]),
        .terms (terms)
    );

    // Branch decision, sine clamp, roll operand select
    always_comb
    begin
        sp      = -terms.cxz;
        thr_q28 = MAT_W'({1'b0, thr_reg, 14'b0});
        if (sp > ONE_Q28)
        begin
            s_clamp = ONE_Q28;
        end
        else if (sp < -ONE_Q28)
        begin
            s_clamp = -ONE_Q28;
        end
        else
        begin
            s_clamp = sp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            lock_pos_reg <= sp >= thr_q28;
            lock_neg_reg <= (sp < thr_q28) && (sp <= -thr_q28);
            s_reg        <= S_W'(s_clamp);
            yaw_y_reg    <= terms.cxy;
            yaw_x_reg    <= terms.cxx;
            if (sp >= thr_q28)
            begin
                roll_y_reg <= terms.cyx;
                roll_x_reg <= terms.cyy;
            end
            else if (sp <= -thr_q28)
            begin
                roll_y_reg <= -terms.cyx;
                roll_x_reg <= terms.cyy;
            end
            else
            begin
                roll_y_reg <= terms.cyz;
                roll_x_reg <= terms.czz;
            end
        end
    end

    // Square the sine
    assign s_prod = s_reg * s_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sq_reg <= s_prod[RAD_W-1:0];
        end
    end

    assign radicand = {1'b1, {(RAD_W-1){1'b0}}} - sq_reg;

    q2e_sqrt u_sqrt (
        .clk      (clk),
        .ce       (ce),
        .radicand (radicand),
        .root     (root)
    );

    q2e_delay #(.WIDTH(S_W), .DEPTH(ALIGN)) u_s_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .din   (s_reg),
        .dout  (s_dly)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .clk   (clk),
        .ce    (ce),
        .y_in  (CORD_W'($signed(s_dly))),
        .x_in  (CORD_W'({1'b0, root})),
        .angle (pitch_ang)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .clk   (clk),
        .ce    (ce),
        .y_in  (CORD_W'(roll_y_reg)),
        .x_in  (CORD_W'(roll_x_reg)),
        .angle (roll_ang)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .clk   (clk),
        .ce    (ce),
        .y_in  (CORD_W'(yaw_y_reg)),
        .x_in  (CORD_W'(yaw_x_reg)),
        .angle (yaw_ang)
    );

    // Align roll and yaw with the pitch path
    q2e_delay #(.WIDTH(ANG_W), .DEPTH(ALIGN)) u_roll_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .din   (roll_ang),
        .dout  (roll_dly)
    );

    q2e_delay #(.WIDTH(ANG_W), .DEPTH(ALIGN)) u_yaw_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .din   (yaw_ang),
        .dout  (yaw_dly)
    );

    q2e_delay #(.WIDTH(2), .DEPTH(ALIGN + CORD_LAT)) u_lock_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .din   ({lock_neg_reg, lock_pos_reg}),
        .dout  (lock_dly)
    );

    q2e_delay #(.WIDTH(1), .DEPTH(VLD_LAT)) u_vld_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .din   (s_axis_tvalid),
        .dout  (vld_dly)
    );

    // Round, saturate and apply the gimbal-lock overrides
    always_comb
    begin
        roll_deg = round_deg($signed(roll_dly), ROLL_LIM);
        if (lock_dly[0])
        begin
            pitch_deg = PITCH_LIM;
            yaw_deg   = '0;
        end
        else if (lock_dly[1])
        begin
            pitch_deg = -PITCH_LIM;
            yaw_deg   = '0;
        end
        else
        begin
            pitch_deg = round_deg(pitch_ang, PITCH_LIM);
            yaw_deg   = round_deg($signed(yaw_dly), ROLL_LIM);
        end
        fin_next = {yaw_deg[YAW_W-1:0], pitch_deg[PITCH_W-1:0], roll_deg[ROLL_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            fin_valid_reg <= vld_dly;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            fin_reg <= fin_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            if (fin_valid_reg)
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (fin_valid_reg)
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_reg <= fin_reg;
                end
                else
                begin
                    skid_reg <= fin_reg;
                end
            end
        end
        else if (m_axis_tready)
        begin
            out_reg <= skid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(48-OUT_W){1'b0}}, out_reg};

endmodule

`default_nettype wire

// ===== tb/q2e_angle_checker.sv =====
// Watches the quaternion and angle streams of the quaternion to Euler core,
// computes the expected angles itself and compares them word by word.
// Depends on q2e_pkg for the field widths.
`timescale 1ns / 100ps

module q2e_angle_checker
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [THR_W-1:0]  cfg_wdata,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [63:0]       s_axis_tdata,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [47:0]       m_axis_tdata,
    output int                     pending,
    output int                     mismatches,
    output int                     lock_hits
);

    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [YAW_W-1:0]   yaw;
    } angles_t;

    localparam longint ONE_FIX = longint'(1) << 28;
    localparam longint RIGHT_ANGLE = longint'(90) << 16;

    angles_t angle_queue[$];
    logic [THR_W-1:0] lock_thr;

    // arctangent of 2^-i in 2^-16 degree
    function automatic longint arctan_step(input int i);
        longint steps[24];
        steps = '{2949120, 1740967, 919879, 466945, 234379, 117306, 58666, 29335,
                  14668, 7334, 3667, 1833, 917, 458, 229, 115,
                  57, 29, 14, 7, 4, 2, 1, 0};
        return (i < 24) ? steps[i] : 0;
    endfunction

    // vectoring CORDIC, result in 2^-16 degree
    function automatic longint vector_angle(input longint vy, input longint vx);
        longint acc;
        longint tmp;
        longint xs;
        longint ys;
        acc = 0;
        if (vx == 0 && vy == 0)
        begin
            return 0;
        end
        // fold the left half plane onto the right
        if (vx < 0)
        begin
            if (vy >= 0)
            begin
                tmp = vx; vx = vy; vy = -tmp; acc = RIGHT_ANGLE;
            end
            else
            begin
                tmp = vx; vx = -vy; vy = tmp; acc = -RIGHT_ANGLE;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy > 0)
            begin
                vx = vx + ys; vy = vy - xs; acc += arctan_step(i);
            end
            else
            begin
                vx = vx - ys; vy = vy + xs; acc -= arctan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b >>= 2;
        end
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
            begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // round to 1/64 degree and clip
    function automatic longint to_sixtyfourths(input longint a, input longint lim);
        longint r;
        r = (a + 512) >>> 10;
        if (r > lim)
        begin
            r = lim;
        end
        if (r < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    function automatic angles_t euler_of(input logic [63:0] q, input logic [THR_W-1:0] thr_q);
        longint qx, qy, qz, qw;
        longint mxx, mxy, mxz, myz, mzz, myx, myy;
        longint sine, cosine, thr;
        longint r, p, yw;
        angles_t a;
        qx = longint'($signed(q[15:0]));
        qy = longint'($signed(q[31:16]));
        qz = longint'($signed(q[47:32]));
        qw = longint'($signed(q[63:48]));
        mxx = ONE_FIX - 2 * (qy * qy + qz * qz);
        mxy = 2 * (qx * qy + qw * qz);
        mxz = 2 * (qx * qz - qw * qy);
        myz = 2 * (qy * qz + qw * qx);
        mzz = ONE_FIX - 2 * (qx * qx + qy * qy);
        myx = 2 * (qx * qy - qw * qz);
        myy = ONE_FIX - 2 * (qx * qx + qz * qz);
        sine = -mxz;
        thr = longint'(thr_q) << 14;
        if (sine >= thr)
        begin
            r = to_sixtyfourths(vector_angle(myx, myy), 11520);
            p = 5760;
            yw = 0;
        end
        else if (sine <= -thr)
        begin
            r = to_sixtyfourths(vector_angle(-myx, myy), 11520);
            p = -5760;
            yw = 0;
        end
        else
        begin
            if (sine > ONE_FIX) sine = ONE_FIX;
            if (sine < -ONE_FIX) sine = -ONE_FIX;
            cosine = longint'(int_sqrt((64'd1 << 56) - longint'(sine * sine)));
            r = to_sixtyfourths(vector_angle(myz, mzz), 11520);
            p = to_sixtyfourths(vector_angle(sine, cosine), 5760);
            yw = to_sixtyfourths(vector_angle(mxy, mxx), 11520);
        end
        a.roll = r[ROLL_W-1:0];
        a.pitch = p[PITCH_W-1:0];
        a.yaw = yw[YAW_W-1:0];
        return a;
    endfunction

    // track the register, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        angles_t exp_a;
        angles_t got;
        if (!rst_n)
        begin
            lock_thr = THR_RESET;
            angle_queue.delete();
            pending = 0;
            mismatches = 0;
            lock_hits = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                lock_thr = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                exp_a = euler_of(s_axis_tdata, lock_thr);
                if (exp_a.pitch == 14'sd5760 || exp_a.pitch == -14'sd5760)
                begin
                    lock_hits++;
                end
                angle_queue.insert(angle_queue.size(), exp_a);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.roll = m_axis_tdata[14:0];
                got.pitch = m_axis_tdata[28:15];
                got.yaw = m_axis_tdata[43:29];
                if (angle_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected word: roll %0d pitch %0d yaw %0d",
                                 got.roll, got.pitch, got.yaw);
                    end
                end
                else
                begin
                    exp_a = angle_queue.pop_front();
                    if (got.roll !== exp_a.roll || got.pitch !== exp_a.pitch
                        || got.yaw !== exp_a.yaw)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("angle mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     exp_a.roll, exp_a.pitch, exp_a.yaw,
                                     got.roll, got.pitch, got.yaw);
                        end
                    end
                end
            end
            pending = angle_queue.size();
        end
    end

endmodule

// ===== tb/tb_quaternion_to_euler_xyz_core.sv =====
// Stimulus and verdict for the quaternion to Euler core: directed and random
// quaternions under several gimbal thresholds and stall patterns.
// Depends on q2e_pkg, the core and q2e_angle_checker.
`timescale 1ns / 100ps

module tb_quaternion_to_euler_xyz_core;
    import q2e_pkg::*;

    localparam int RAND_PER_PHASE = 226;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [THR_W-1:0]  cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [47:0]       m_axis_tdata;
    int                pending;
    int                mismatches;
    int                lock_hits;
    int                tx_idle;
    int                rx_idle;
    int                words_sent;

    quaternion_to_euler_xyz_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    q2e_angle_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .pending(pending), .mismatches(mismatches), .lock_hits(lock_hits)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // stall the receiver at random
    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(99) >= rx_idle);
    end

    // hard stop
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // drive one word, holding it until accepted
    task automatic send_quat(input logic signed [15:0] qx, input logic signed [15:0] qy,
                             input logic signed [15:0] qz, input logic signed [15:0] qw);
        while ($urandom_range(99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {qw, qz, qy, qx};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        words_sent++;
    endtask

    // drain, settle, then write the threshold
    task automatic set_threshold(input logic [THR_W-1:0] thr);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (60) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random;
        int kind;
        int m;
        logic signed [15:0] a;
        kind = $urandom_range(9);
        if (kind < 4)
        begin
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        else if (kind < 8)
        begin
            // roughly unit-sized components
            send_quat(16'(int'($urandom_range(23170)) - 11585),
                      16'(int'($urandom_range(23170)) - 11585),
                      16'(int'($urandom_range(23170)) - 11585),
                      16'(int'($urandom_range(23170)) - 11585));
        end
        else
        begin
            // close to gimbal lock on either side
            m = $urandom_range(11600, 11560);
            a = 16'(m);
            if ($urandom_range(1)) a = -a;
            send_quat(16'(int'($urandom_range(200)) - 100), a,
                      16'(int'($urandom_range(200)) - 100), 16'(m));
        end
    endtask

    initial
    begin
        logic [THR_W-1:0] thr_list[5];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        words_sent = 0;
        tx_idle = 33;
        rx_idle = 65;
        thr_list = '{15'd16384, 15'd0, 15'h7FFF, 15'd16383, 15'd0};
        thr_list[4] = THR_W'($urandom_range(16384, 15000));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset threshold
        send_quat(0, 0, 0, 16'sd16384);
        send_quat(16'sd16384, 0, 0, 0);
        send_quat(0, 16'sd16384, 0, 0);
        send_quat(0, 0, 16'sd16384, 0);
        send_quat(0, 0, 0, 0);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_quat(0, 16'sd11586, 0, 16'sd11586);
        send_quat(0, -16'sd11586, 0, 16'sd11586);
        send_quat(0, 16'sd11585, 0, 16'sd11585);
        send_quat(16'sd1000, 16'sd11586, -16'sd800, 16'sd11586);
        send_quat(0, 16'sd20000, 0, 16'sd20000);
        send_quat(0, -16'sd20000, 0, 16'sd20000);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        send_quat(-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192);

        for (int ph = 0; ph < 5; ph++)
        begin
            set_threshold(thr_list[ph]);
            if (ph == 2)
            begin
                tx_idle = 65;
                rx_idle = 33;
            end
            if (ph == 4)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            // a word at the edge of gimbal lock on each side and a sine of zero under each threshold
            send_quat(0, 16'sd11586, 0, 16'sd11586);
            send_quat(0, -16'sd11586, 0, 16'sd11586);
            send_quat(16'sd16384, 0, 0, 0);
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                send_random();
            end
        end
        // a few words with only the receiver idle
        rx_idle = 65;
        for (int n = 0; n < 20; n++)
        begin
            send_random();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (80) @(posedge clk);
        $display("run: %0d quaternions over five thresholds, %0d hit pitch +/-90",
                 words_sent, lock_hits);
        if (mismatches == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/q2e_pkg.sv
sv/q2e_delay.sv
sv/q2e_matrix.sv
sv/q2e_sqrt.sv
sv/q2e_cordic.sv
sv/quaternion_to_euler_xyz_core.sv
tb/q2e_angle_checker.sv
tb/tb_quaternion_to_euler_xyz_core.sv
